>>> sv/rgff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgff_pkg;

    // Field and coordinate widths.
    localparam int CRD_W  = 9;
    localparam int CFG_W  = 9;
    localparam int PIX_W  = 8;
    localparam int CNT_W  = 17;
    localparam int IDX_W  = 2;
    localparam int STK_W  = 2 * CRD_W;

    localparam logic [PIX_W-1:0] SEED_MARK = 8'hFF;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THR  = 2'd2;

    typedef enum logic [1:0] {
        FN_LOAD = 2'd0,
        FN_GROW = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SEED,
        ST_POP,
        ST_POPW,
        ST_CURW,
        ST_NB,
        ST_NBT
    } t_state;

    typedef struct packed {
        t_func            func;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] gray;
        logic             edge_req;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0] read_value;
        logic             grown;
        logic [CNT_W-1:0] grown_count;
        logic             status;
    } t_res;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctrl_stat;

    typedef struct packed {
        logic             valid;
        logic [CRD_W-1:0] nx;
        logic [CRD_W-1:0] ny;
    } t_nbr;

    // Column step of each neighbor, clockwise from up-left.
    function automatic logic signed [1:0] dir_dx(input logic [2:0] k);
        unique case (k)
            3'd0, 3'd6, 3'd7: dir_dx = -2'sd1;
            3'd1, 3'd5:       dir_dx = 2'sd0;
            default:          dir_dx = 2'sd1;
        endcase
    endfunction

    // Row step of each neighbor, clockwise from up-left.
    function automatic logic signed [1:0] dir_dy(input logic [2:0] k);
        unique case (k)
            3'd0, 3'd1, 3'd2: dir_dy = -2'sd1;
            3'd3, 3'd7:       dir_dy = 2'sd0;
            default:          dir_dy = 2'sd1;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> sv/rgff_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rgff_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] gray;
    logic       edge_req;

    modport source (output valid, func, x, y, gray, edge_req, input ready);
    modport sink   (input valid, func, x, y, gray, edge_req, output ready);
endinterface

`default_nettype wire

>>> sv/rgff_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rgff_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_value;
    logic        grown;
    logic [16:0] grown_count;
    logic        status;

    modport source (output valid, read_value, grown, grown_count, status, input ready);
    modport sink   (input valid, read_value, grown, grown_count, status, output ready);
endinterface

`default_nettype wire

>>> sv/rgff_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rgff_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/region_grow_flood_fill_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Load, read and undefined requests need no sweep: a read in the image passes through the read state,
// the others finish from idle, and the response is then registered. A grow first sweeps the result
// map clear, then tests the neighbors of each region pixel in turn through the single neighbor test unit.
// One request at a time: a new one is taken once the previous response is delivered.
// Synchronous active-low reset starts a clearing pass over the whole result map,
// and the block is not ready meanwhile.
module region_grow_flood_fill_unit import rgff_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rgff_req_if.sink    i_req,
    rgff_cfg_if.sink    i_cfg,
    rgff_rsp_if.source  o_rsp
);

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;
    logic [CFG_W-1:0] r_thr;
    logic             r_out_valid;
    t_res             r_out;

    logic [CFG_W-1:0] eff_cols;
    logic [CFG_W-1:0] eff_rows;
    t_item            item;
    t_ctrl_stat       stat;
    t_res             res;
    logic             start;

    // Configuration writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= 9'd256;
            r_rows <= 9'd256;
            r_thr  <= 9'd10;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COLS: r_cols <= i_cfg.data;
                CFG_ROWS: r_rows <= i_cfg.data;
                CFG_THR:  r_thr  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Image size in use is capped by the memory geometry.
    assign eff_cols = (32'(r_cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : r_cols;
    assign eff_rows = (32'(r_rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : r_rows;

    assign item = '{func: t_func'(i_req.func), x: i_req.x, y: i_req.y,
                    gray: i_req.gray, edge_req: i_req.edge_req};

    assign i_req.ready = stat.idle && !r_out_valid;
    assign start       = i_req.valid && i_req.ready;

    rgff_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (item),
        .i_cols  (eff_cols),
        .i_rows  (eff_rows),
        .i_thr   (r_thr),
        .o_stat  (stat),
        .o_res   (res)
    );

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.grown       = r_out.grown;
    assign o_rsp.grown_count = r_out.grown_count;
    assign o_rsp.status      = r_out.status;

endmodule

`default_nettype wire

>>> sv/rgff_nbr_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared neighbor unit: steps from the current pixel, checks bounds, forms the
// address and compares gray levels against the threshold.
module rgff_nbr_unit import rgff_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int AW       = 16
) (
    input  wire logic [CRD_W-1:0] i_cx,
    input  wire logic [CRD_W-1:0] i_cy,
    input  wire logic [2:0]       i_dir,
    input  wire logic [CFG_W-1:0] i_cols,
    input  wire logic [CFG_W-1:0] i_rows,
    input  wire logic [PIX_W-1:0] i_cur_gray,
    input  wire logic [PIX_W-1:0] i_nb_gray,
    input  wire logic [CFG_W-1:0] i_thr,
    output t_nbr                  o_nbr,
    output logic [AW-1:0]         o_addr,
    output logic                  o_close
);

    logic signed [1:0]  dx;
    logic signed [1:0]  dy;
    logic [CRD_W+1:0]   sx;
    logic [CRD_W+1:0]   sy;
    logic [PIX_W-1:0]   diff;

    assign dx = dir_dx(i_dir);
    assign dy = dir_dy(i_dir);

    // A step left of column 0 or above row 0 wraps and sets the top bit.
    assign sx = {2'b00, i_cx} + {{CRD_W{dx[1]}}, dx};
    assign sy = {2'b00, i_cy} + {{CRD_W{dy[1]}}, dy};

    assign o_nbr.valid = !sx[CRD_W+1] && !sy[CRD_W+1]
                         && (sx[CRD_W:0] < {1'b0, i_cols})
                         && (sy[CRD_W:0] < {1'b0, i_rows});
    assign o_nbr.nx = sx[CRD_W-1:0];
    assign o_nbr.ny = sy[CRD_W-1:0];

    assign o_addr = AW'(o_nbr.ny) * AW'(MAX_COLS) + AW'(o_nbr.nx);

    // Absolute gray difference, strictly below the threshold.
    assign diff    = (i_cur_gray >= i_nb_gray) ? (i_cur_gray - i_nb_gray)
                                               : (i_nb_gray - i_cur_gray);
    assign o_close = {1'b0, diff} < i_thr;

endmodule

`default_nettype wire

>>> sv/rgff_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer with the pixel, result and stack memories. It sweeps the result
// map clear, then runs the stack fill one neighbor test at a time.
module rgff_ctrl import rgff_pkg::*; #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire t_item            i_item,
    input  wire logic [CFG_W-1:0] i_cols,
    input  wire logic [CFG_W-1:0] i_rows,
    input  wire logic [CFG_W-1:0] i_thr,
    output t_ctrl_stat            o_stat,
    output t_res                  o_res
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SDW   = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    t_item              r_item;
    logic [AW-1:0]      r_sweep;
    logic               r_post_grow;
    logic [SDW-1:0]     r_sp;
    logic [SDW-1:0]     r_count;
    logic [CRD_W-1:0]   r_cx;
    logic [CRD_W-1:0]   r_cy;
    logic [PIX_W-1:0]   r_cg;
    logic [2:0]         r_dir;
    logic [AW-1:0]      r_na;
    logic [STK_W-1:0]   r_nxy;
    logic               r_done;
    t_res               r_res;

    // Memories: {outline, gray}, {grown, value}, and the point stack.
    logic [PIX_W:0]     src_mem [DEPTH];
    logic [PIX_W:0]     rmap_mem [DEPTH];
    logic [STK_W-1:0]   stk_mem [DEPTH];
    logic [PIX_W:0]     src_rd;
    logic [PIX_W:0]     rmap_rd;
    logic [STK_W-1:0]   stk_rd;

    logic               src_we;
    logic [AW-1:0]      src_wa;
    logic [AW-1:0]      src_ra;
    logic               rmap_we;
    logic [AW-1:0]      rmap_wa;
    logic [PIX_W:0]     rmap_wd;
    logic [AW-1:0]      rmap_ra;
    logic               stk_we;
    logic [AW-1:0]      stk_wa;
    logic [STK_W-1:0]   stk_wd;
    logic [AW-1:0]      stk_ra;

    logic               in_inside;
    logic [AW-1:0]      in_addr;
    logic               seed_inside;
    logic [AW-1:0]      seed_addr;
    logic [AW-1:0]      cur_addr;
    logic               sweep_last;
    logic               join_ok;

    t_nbr               nbr;
    logic [AW-1:0]      nb_addr;
    logic               nb_close;

    // Address and bounds of the incoming item and of the latched seed.
    assign in_inside   = ({1'b0, i_item.x} < i_cols) && ({1'b0, i_item.y} < i_rows);
    assign in_addr     = AW'(i_item.y) * AW'(MAX_COLS) + AW'(i_item.x);
    assign seed_inside = ({1'b0, r_item.x} < i_cols) && ({1'b0, r_item.y} < i_rows);
    assign seed_addr   = AW'(r_item.y) * AW'(MAX_COLS) + AW'(r_item.x);
    assign cur_addr    = AW'(stk_rd[STK_W-1:CRD_W]) * AW'(MAX_COLS)
                         + AW'(stk_rd[CRD_W-1:0]);
    assign sweep_last  = (r_sweep == AW'(DEPTH - 1));
    assign join_ok     = !src_rd[PIX_W] && !rmap_rd[PIX_W] && nb_close;

    rgff_nbr_unit #(
        .MAX_COLS (MAX_COLS),
        .AW       (AW)
    ) u_nbr (
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_dir      (r_dir),
        .i_cols     (i_cols),
        .i_rows     (i_rows),
        .i_cur_gray (r_cg),
        .i_nb_gray  (src_rd[PIX_W-1:0]),
        .i_thr      (i_thr),
        .o_nbr      (nbr),
        .o_addr     (nb_addr),
        .o_close    (nb_close)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (sweep_last) begin
                    n_state = r_post_grow ? ST_SEED : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start && i_item.func == FN_GROW) begin
                    n_state = ST_CLEAR;
                end else if (i_start && i_item.func == FN_READ && in_inside) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_SEED: n_state = seed_inside ? ST_POP : ST_IDLE;
            ST_POP:  n_state = (r_sp == '0) ? ST_IDLE : ST_POPW;
            ST_POPW: n_state = ST_CURW;
            ST_CURW: n_state = ST_NB;
            ST_NB: begin
                if (nbr.valid) begin
                    n_state = ST_NBT;
                end else if (r_dir == 3'd7) begin
                    n_state = ST_POP;
                end
            end
            ST_NBT:  n_state = (r_dir == 3'd7) ? ST_POP : ST_NB;
            default: n_state = ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        src_we  = 1'b0;
        src_wa  = in_addr;
        src_ra  = nb_addr;
        rmap_we = 1'b0;
        rmap_wa = r_sweep;
        rmap_wd = '0;
        rmap_ra = nb_addr;
        stk_we  = 1'b0;
        stk_wa  = AW'(r_sp);
        stk_wd  = r_nxy;
        stk_ra  = AW'(r_sp - 1'b1);
        unique case (r_state)
            ST_CLEAR: rmap_we = 1'b1;
            ST_IDLE: begin
                src_we  = i_start && i_item.func == FN_LOAD && in_inside;
                rmap_ra = in_addr;
            end
            ST_SEED: begin
                rmap_we = seed_inside;
                rmap_wa = seed_addr;
                rmap_wd = {1'b1, SEED_MARK};
                stk_we  = seed_inside;
                stk_wa  = '0;
                stk_wd  = {1'b0, r_item.y, 1'b0, r_item.x};
            end
            ST_POPW:  src_ra = cur_addr;
            ST_NBT: begin
                rmap_we = join_ok;
                rmap_wa = r_na;
                rmap_wd = {1'b1, src_rd[PIX_W-1:0]};
                stk_we  = join_ok;
            end
            ST_READ, ST_POP, ST_CURW, ST_NB: begin
            end
            default: begin
            end
        endcase
    end

    // Pixel memory.
    always_ff @(posedge i_clk) begin
        if (src_we) begin
            src_mem[src_wa] <= {i_item.edge_req, i_item.gray};
        end
        src_rd <= src_mem[src_ra];
    end

    // Result map with grown bit.
    always_ff @(posedge i_clk) begin
        if (rmap_we) begin
            rmap_mem[rmap_wa] <= rmap_wd;
        end
        rmap_rd <= rmap_mem[rmap_ra];
    end

    // Point stack.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_rd <= stk_mem[stk_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_sweep     <= '0;
            r_post_grow <= 1'b0;
            r_sp        <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                ST_CLEAR: r_sweep <= r_sweep + 1'b1;
                ST_IDLE: begin
                    if (i_start) begin
                        r_sweep     <= '0;
                        r_post_grow <= 1'b1;
                        r_done      <= !(i_item.func == FN_GROW)
                                       && !(i_item.func == FN_READ && in_inside);
                    end
                end
                ST_READ:  r_done <= 1'b1;
                ST_SEED: begin
                    r_sp   <= seed_inside ? SDW'(1) : '0;
                    r_done <= !seed_inside;
                end
                ST_POP: begin
                    if (r_sp == '0) begin
                        r_done <= 1'b1;
                    end else begin
                        r_sp <= r_sp - 1'b1;
                    end
                end
                ST_NBT: begin
                    if (join_ok) begin
                        r_sp <= r_sp + 1'b1;
                    end
                end
                ST_POPW, ST_CURW, ST_NB: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_item <= i_item;
                    r_res  <= '{read_value: '0, grown: 1'b0, grown_count: '0,
                               status: (i_item.func != FN_NONE) && !in_inside};
                end
            end
            ST_READ: begin
                r_res.read_value <= rmap_rd[PIX_W-1:0];
                r_res.grown      <= rmap_rd[PIX_W];
            end
            ST_SEED:  r_count <= seed_inside ? SDW'(1) : '0;
            ST_POP: begin
                if (r_sp == '0) begin
                    r_res.grown_count <= CNT_W'(r_count);
                end
            end
            ST_POPW: begin
                r_cx <= stk_rd[CRD_W-1:0];
                r_cy <= stk_rd[STK_W-1:CRD_W];
            end
            ST_CURW: begin
                r_cg  <= src_rd[PIX_W-1:0];
                r_dir <= '0;
            end
            ST_NB: begin
                r_na  <= nb_addr;
                r_nxy <= {nbr.ny, nbr.nx};
                if (!nbr.valid) begin
                    r_dir <= r_dir + 1'b1;
                end
            end
            ST_NBT: begin
                r_dir <= r_dir + 1'b1;
                if (join_ok) begin
                    r_count <= r_count + 1'b1;
                end
            end
            ST_CLEAR: begin
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle = (r_state == ST_IDLE) && !r_done;
    assign o_stat.done = r_done;
    assign o_res       = r_res;

    // A finished request reports once.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");

    // An empty stack ends the grow in the next cycle.
    a_pop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP && r_sp == '0) |=> r_done)
        else $error("empty stack did not finish the grow");

    // The clearing pass after reset reports nothing.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !r_post_grow) |-> !r_done)
        else $error("result reported during the reset clearing pass");

    // A push never runs past the stack.
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> (r_sp < SDW'(DEPTH)))
        else $error("stack overflow");

endmodule

`default_nettype wire

>>> tb/sv/region_grow_flood_fill_unit_tb.sv
`timescale 1ns / 1ps

module region_grow_flood_fill_unit_tb;
    import rgff_pkg::*;

    localparam int COLS_MAX    = 256;
    localparam int ROWS_MAX    = 256;
    localparam int PIXELS      = COLS_MAX * ROWS_MAX;
    localparam int CYCLE_LIMIT = 6000000;

    logic i_clk;
    logic i_rst_n;

    rgff_req_if req_if ();
    rgff_cfg_if cfg_if ();
    rgff_rsp_if rsp_if ();

    region_grow_flood_fill_unit #(
        .MAX_COLS(COLS_MAX),
        .MAX_ROWS(ROWS_MAX)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .i_cfg  (cfg_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // Shadow copy of the block's memories and registers.
    logic [7:0] gray_mem [PIXELS];
    logic       barrier_mem [PIXELS];
    logic [7:0] region_mem [PIXELS];
    logic       member_mem [PIXELS];
    int         width_reg;
    int         height_reg;
    int         thresh_reg;

    t_item pending_reqs[$];
    t_res  awaited_rsps[$];
    int    mismatch_count;
    int    cycle_count;
    bit    req_taken;
    int    burst_left;
    int    gap_left;
    bit    rsp_stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int used_cols();
        return (width_reg > COLS_MAX) ? COLS_MAX : width_reg;
    endfunction

    function automatic int used_rows();
        return (height_reg > ROWS_MAX) ? ROWS_MAX : height_reg;
    endfunction

    // Appends one request to the driver's queue.
    function automatic void add_req(t_item it);
        pending_reqs.insert(pending_reqs.size(), it);
    endfunction

    // Flood fill of the shadow maps; returns the region size.
    function automatic int flood_region(int sx, int sy);
        int pending_pts[$];
        int members;
        int cur;
        int nx;
        int ny;
        int na;
        int diff;
        int dxs[8];
        int dys[8];
        dxs = '{-1, 0, 1, 1, 1, 0, -1, -1};
        dys = '{-1, -1, -1, 0, 1, 1, 1, 0};
        members = 1;
        region_mem[sy * COLS_MAX + sx] = SEED_MARK;
        member_mem[sy * COLS_MAX + sx] = 1'b1;
        pending_pts.insert(pending_pts.size(), sy * COLS_MAX + sx);
        while (pending_pts.size() > 0) begin
            cur = pending_pts[pending_pts.size() - 1];
            pending_pts.delete(pending_pts.size() - 1);
            for (int k = 0; k < 8; k++) begin
                nx = cur % COLS_MAX + dxs[k];
                ny = cur / COLS_MAX + dys[k];
                if (nx < 0 || ny < 0 || nx >= used_cols() || ny >= used_rows()) continue;
                na = ny * COLS_MAX + nx;
                if (barrier_mem[na] || member_mem[na]) continue;
                diff = int'(gray_mem[cur]) - int'(gray_mem[na]);
                if (diff < 0) diff = -diff;
                if (diff >= thresh_reg) continue;
                region_mem[na] = gray_mem[na];
                member_mem[na] = 1'b1;
                members++;
                pending_pts.insert(pending_pts.size(), na);
            end
        end
        return members;
    endfunction

    // Expected response for one accepted request, updating the shadow state.
    function automatic t_res predict_response(t_item it);
        t_res r;
        bit   in_img;
        int   a;
        r = '0;
        in_img = (int'(it.x) < used_cols()) && (int'(it.y) < used_rows());
        a = int'(it.y) * COLS_MAX + int'(it.x);
        case (it.func)
            FN_LOAD: begin
                if (in_img) begin
                    gray_mem[a] = it.gray;
                    barrier_mem[a] = it.edge_req;
                end else begin
                    r.status = 1'b1;
                end
            end
            FN_GROW: begin
                for (int i = 0; i < PIXELS; i++) begin
                    region_mem[i] = '0;
                    member_mem[i] = 1'b0;
                end
                if (in_img) r.grown_count = CNT_W'(flood_region(it.x, it.y));
                else r.status = 1'b1;
            end
            FN_READ: begin
                if (in_img) begin
                    r.read_value = region_mem[a];
                    r.grown = member_mem[a];
                end else begin
                    r.status = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Acceptance, prediction and response checking at the rising edge.
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        t_item it;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got.read_value = rsp_if.read_value;
            got.grown = rsp_if.grown;
            got.grown_count = rsp_if.grown_count;
            got.status = rsp_if.status;
            if (awaited_rsps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Response with no request pending: %p", got);
            end else begin
                want = awaited_rsps.pop_front();
                if (got.read_value !== want.read_value || got.grown !== want.grown ||
                    got.grown_count !== want.grown_count || got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, actual %p", want, got);
                end
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready) begin
            it.func = t_func'(req_if.func);
            it.x = req_if.x;
            it.y = req_if.y;
            it.gray = req_if.gray;
            it.edge_req = req_if.edge_req;
            awaited_rsps.insert(awaited_rsps.size(), predict_response(it));
        end
    end

    // Request driver: bursts of requests with random gaps between them.
    always @(negedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_taken) begin
            req_if.valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            it = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.func <= it.func;
            req_if.x <= it.x;
            req_if.y <= it.y;
            req_if.gray <= it.gray;
            req_if.edge_req <= it.edge_req;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Response sink stalls in its own pattern while stall mode is on.
    always @(negedge i_clk) begin
        if (rsp_stall_mode) rsp_if.ready <= ($urandom_range(0, 3) != 0) && (cycle_count % 23 > 4);
        else rsp_if.ready <= 1'b1;
    end

    function automatic t_item make_req(t_func f, int x, int y, int g, bit b);
        t_item it;
        it.func = f;
        it.x = 8'(x);
        it.y = 8'(y);
        it.gray = 8'(g);
        it.edge_req = b;
        return it;
    endfunction

    // Lets all outstanding requests drain before touching the registers.
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_if.valid || awaited_rsps.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= 9'(value);
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_COLS: width_reg = value;
            CFG_ROWS: height_reg = value;
            default:  thresh_reg = value;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic random_coord_outside(output int x, output int y);
        do begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
        end while (x < used_cols() && y < used_rows());
    endtask

    // One setting: fill the image in use, then a random mix with a few grows.
    task automatic run_phase(int cols, int rows, int thr, int grows, int mixed);
        int base;
        int x;
        int y;
        int pick;
        int w;
        int h;
        wait_idle();
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_THR, thr);
        rsp_stall_mode = $urandom_range(0, 1);
        w = used_cols();
        h = used_rows();
        base = $urandom_range(0, 255);
        for (int yy = 0; yy < h; yy++)
            for (int xx = 0; xx < w; xx++)
                add_req(make_req(FN_LOAD, xx, yy,
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                : (base + $urandom_range(0, 12)) % 256,
                    $urandom_range(0, 7) == 0));
        for (int n = 0; n < mixed; n++) begin
            pick = $urandom_range(0, 99);
            if (w == 0 || h == 0 || pick >= 85) begin
                random_coord_outside(x, y);
                add_req(make_req(t_func'($urandom_range(0, 3)), x, y,
                    $urandom_range(0, 255), $urandom_range(0, 1)));
            end else begin
                x = $urandom_range(0, w - 1);
                y = $urandom_range(0, h - 1);
                if (n % (mixed / (grows + 1) + 1) == mixed / (grows + 1) && grows > 0) begin
                    add_req(make_req(FN_GROW, x, y, 0, 0));
                    grows--;
                end else if (pick < 25) begin
                    add_req(make_req(FN_LOAD, x, y,
                        (base + $urandom_range(0, 12)) % 256, $urandom_range(0, 7) == 0));
                end else begin
                    add_req(make_req(FN_READ, x, y,
                        $urandom_range(0, 255), $urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.func = FN_LOAD;
        req_if.x = '0;
        req_if.y = '0;
        req_if.gray = '0;
        req_if.edge_req = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_COLS;
        cfg_if.data = '0;
        rsp_if.ready = 1'b1;
        rsp_stall_mode = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        req_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        width_reg = 256;
        height_reg = 256;
        thresh_reg = 10;
        for (int i = 0; i < PIXELS; i++) begin
            gray_mem[i] = '0;
            barrier_mem[i] = 1'b0;
            region_mem[i] = '0;
            member_mem[i] = 1'b0;
        end
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a small 4x3 image with extreme grays and outline pixels.
        write_reg(CFG_COLS, 4);
        write_reg(CFG_ROWS, 3);
        write_reg(CFG_THR, 10);
        add_req(make_req(FN_LOAD, 0, 0, 0, 0));
        add_req(make_req(FN_LOAD, 1, 0, 5, 0));
        add_req(make_req(FN_LOAD, 2, 0, 9, 1));
        add_req(make_req(FN_LOAD, 3, 0, 255, 0));
        add_req(make_req(FN_LOAD, 0, 1, 3, 0));
        add_req(make_req(FN_LOAD, 1, 1, 8, 0));
        add_req(make_req(FN_LOAD, 2, 1, 100, 0));
        add_req(make_req(FN_LOAD, 3, 1, 250, 0));
        add_req(make_req(FN_LOAD, 0, 2, 12, 0));
        add_req(make_req(FN_LOAD, 1, 2, 17, 0));
        add_req(make_req(FN_LOAD, 2, 2, 245, 0));
        add_req(make_req(FN_LOAD, 3, 2, 255, 1));
        add_req(make_req(FN_READ, 1, 1, 0, 0));
        add_req(make_req(FN_GROW, 1, 1, 0, 0));
        add_req(make_req(FN_READ, 1, 1, 0, 0));
        add_req(make_req(FN_READ, 0, 0, 0, 0));
        add_req(make_req(FN_READ, 3, 1, 0, 0));
        add_req(make_req(FN_READ, 255, 255, 255, 1));
        add_req(make_req(FN_LOAD, 200, 3, 77, 1));
        add_req(make_req(FN_NONE, 255, 255, 255, 1));
        // A seed sitting on an outline pixel still grows.
        add_req(make_req(FN_GROW, 3, 2, 0, 0));
        add_req(make_req(FN_READ, 3, 2, 0, 0));
        add_req(make_req(FN_GROW, 4, 0, 0, 0));
        add_req(make_req(FN_READ, 3, 2, 0, 0));

        // Random phases over sizes and thresholds, extremes included.
        run_phase(6, 5, 10, 2, 40);
        run_phase(511, 1, 256, 2, 30);
        run_phase(1, 256, 0, 2, 30);
        run_phase(0, 5, 10, 1, 25);
        run_phase(8, 6, 40, 3, 50);
        run_phase(5, 0, 3, 1, 20);
        run_phase(6, 7, 200, 2, 40);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
sv/rgff_pkg.sv
sv/rgff_req_if.sv
sv/rgff_rsp_if.sv
sv/rgff_cfg_if.sv
sv/rgff_nbr_unit.sv
sv/rgff_ctrl.sv
sv/region_grow_flood_fill_unit.sv
tb/sv/region_grow_flood_fill_unit_tb.sv
